### hdl/clrr_pkg.sv
// clrr_pkg: shared types, constants and seed reload functions for the
// combined lfsr random range block; used by every module in hdl
package clrr_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned ShortW = 31;
  localparam int unsigned RawW   = 16;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned CntW   = $clog2(RawW);

  localparam logic [DataW-1:0]  SeedOffset     = 32'h2F2F_2F2F;
  localparam logic [DataW-1:0]  ResetSeed      = 32'h0000_0001;
  localparam logic [DataW-1:0]  ResetTapsLong  = 32'hB4BC_D35C;
  localparam logic [ShortW-1:0] ResetTapsShort = 31'h7A5B_C2E3;
  localparam logic [DataW-1:0]  ModLong        = 32'hFFFF_FFFF;
  localparam logic [DataW-1:0]  ModShort       = 32'h7FFF_FFFF;

  typedef enum logic [IdxW-1:0] {
    REG_SEED       = 2'd0,
    REG_TAPS_LONG  = 2'd1,
    REG_TAPS_SHORT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RAW,
    ST_DIV,
    ST_RESULT
  } seq_state_e;

  // seed mod (2^32 - 1): only the all-ones seed wraps
  function automatic logic [DataW-1:0] reload_long(input logic [DataW-1:0] seed);
    logic [DataW-1:0] r;
    r = (seed == ModLong) ? '0 : seed;
    return r;
  endfunction

  // (seed + offset) mod (2^31 - 1), using 2^31 == 1 mod (2^31 - 1)
  function automatic logic [ShortW-1:0] reload_short(input logic [DataW-1:0] seed);
    logic [DataW-1:0] s;
    logic [DataW-1:0] t;
    s = seed + SeedOffset;
    t = {1'b0, s[ShortW-1:0]} + {{(DataW-1){1'b0}}, s[DataW-1]};
    if (t >= ModShort) begin
      t = t - ModShort;
    end
    return t[ShortW-1:0];
  endfunction

endpackage

### hdl/clrr_lfsr.sv
// clrr_lfsr: the 32-bit and 31-bit galois shift registers, their tap masks
// and the seed reload; depends on clrr_pkg
module clrr_lfsr
  import clrr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [DataW-1:0] cfg_data_i,
  input  logic             step_i,
  output logic [RawW-1:0]  raw_o
);

  logic [DataW-1:0]  long_q, long_d;
  logic [ShortW-1:0] short_q, short_d;
  logic [DataW-1:0]  taps_long_q, taps_long_d;
  logic [ShortW-1:0] taps_short_q, taps_short_d;
  logic [DataW-1:0]  long_mid;

  always_comb begin
    long_d       = long_q;
    short_d      = short_q;
    taps_long_d  = taps_long_q;
    taps_short_d = taps_short_q;
    // two steps of the long register, one of the short
    long_mid = (long_q >> 1) ^ (long_q[0] ? taps_long_q : '0);
    if (step_i) begin
      long_d  = (long_mid >> 1) ^ (long_mid[0] ? taps_long_q : '0);
      short_d = (short_q >> 1) ^ (short_q[0] ? taps_short_q : '0);
    end
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SEED: begin
          long_d  = reload_long(cfg_data_i);
          short_d = reload_short(cfg_data_i);
        end
        REG_TAPS_LONG:  taps_long_d  = cfg_data_i;
        REG_TAPS_SHORT: taps_short_d = cfg_data_i[ShortW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q       <= reload_long(ResetSeed);
      short_q      <= reload_short(ResetSeed);
      taps_long_q  <= ResetTapsLong;
      taps_short_q <= ResetTapsShort;
    end else begin
      long_q       <= long_d;
      short_q      <= short_d;
      taps_long_q  <= taps_long_d;
      taps_short_q <= taps_short_d;
    end
  end

  assign raw_o = long_q[RawW-1:0] ^ short_q[RawW-1:0];

endmodule

### hdl/clrr_urem.sv
// clrr_urem: restoring remainder unit, one dividend bit per cycle, one
// shared compare and subtract; depends on clrr_pkg
module clrr_urem
  import clrr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RawW-1:0]  dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [RawW-1:0]  rem_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [RawW-1:0]  quot_q, quot_d;
  logic [RawW-1:0]  rem_q, rem_d;
  logic [RawW:0]    shifted;
  logic [RawW:0]    diff;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    shifted = {rem_q, quot_q[RawW-1]};
    diff    = shifted - divisor_i[RawW:0];
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quot_d = quot_q << 1;
      // divisor at most the shifted remainder: take the subtraction
      if ({{(DataW-RawW-1){1'b0}}, shifted} >= divisor_i) begin
        rem_d = diff[RawW-1:0];
      end else begin
        rem_d = shifted[RawW-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### hdl/combined_lfsr_random_range.sv
// Random source from a 32-bit and a 31-bit galois lfsr, optionally reduced to
// [range_low, range_high). One word is taken at a time: a raw request passes
// through the raw and result states to the output register, a range request
// also through the 16-step remainder unit (one dividend bit per cycle); equal
// bounds in range mode give span_error with value 0 and leave the lfsrs
// untouched. The output register lets the next word be accepted while a
// result waits. Writing the seed register reloads both lfsrs at once.
module combined_lfsr_random_range
  import clrr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IdxW-1:0]    cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [2*DataW-1:0] s_axis_tdata,  // range_low, range_high
  input  logic               s_axis_tuser,  // func
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DataW-1:0]   m_axis_tdata,  // value
  output logic               m_axis_tuser   // span_error
);

  seq_state_e       state_q, state_d;
  logic             func_q, func_d;
  logic             err_q, err_d;
  logic [DataW-1:0] low_q, low_d;
  logic [DataW-1:0] span_q, span_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_value_q, out_value_d;
  logic             out_err_q, out_err_d;

  logic             in_fire;
  logic             step;
  logic             urem_start;
  logic             urem_done;
  logic [RawW-1:0]  raw;
  logic [RawW-1:0]  rem;
  logic [DataW-1:0] span_in;
  logic [DataW-1:0] result;

  clrr_lfsr u_lfsr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .raw_o       (raw)
  );

  clrr_urem u_urem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (urem_start),
    .dividend_i (raw),
    .divisor_i  (span_q),
    .done_o     (urem_done),
    .rem_o      (rem)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign span_in       = s_axis_tdata[2*DataW-1:DataW] - s_axis_tdata[DataW-1:0];

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    err_d       = err_q;
    low_d       = low_q;
    span_d      = span_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_err_d   = out_err_q;
    step        = 1'b0;
    urem_start  = 1'b0;

    if (err_q) begin
      result = '0;
    end else if (func_q) begin
      result = {{(DataW-RawW){1'b0}}, rem} + low_q;
    end else begin
      result = {{(DataW-RawW){1'b0}}, raw};
    end

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          func_d = s_axis_tuser;
          low_d  = s_axis_tdata[DataW-1:0];
          span_d = span_in;
          err_d  = s_axis_tuser && (span_in == '0);
          if (s_axis_tuser && (span_in == '0)) begin
            state_d = ST_RESULT;
          end else begin
            step    = 1'b1;
            state_d = ST_RAW;
          end
        end
      end
      ST_RAW: begin
        if (func_q) begin
          urem_start = 1'b1;
          state_d    = ST_DIV;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_DIV: begin
        if (urem_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_value_d = result;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    err_q       <= err_d;
    low_q       <= low_d;
    span_q      <= span_d;
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_err_q;

endmodule

### dv/testbench.sv
// testbench for combined_lfsr_random_range: drives random-number requests over the
// input stream and checks each returned word against a built-in lfsr/range predictor
// depends on hdl/clrr_pkg.sv and hdl/combined_lfsr_random_range.sv
`timescale 1ns / 100ps

module testbench;
  import clrr_pkg::*;

  localparam logic FuncRaw   = 1'b0;
  localparam logic FuncRange = 1'b1;
  localparam logic [IdxW-1:0] RegUnused = 2'd3;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic             func;
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
  } request_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             span_error;
  } rand_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [IdxW-1:0]    cfg_index_i = '0;
  logic [DataW-1:0]   cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [2*DataW-1:0] s_axis_tdata = '0;  // range_low, range_high
  logic               s_axis_tuser = 1'b0;  // func
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [DataW-1:0]   m_axis_tdata;  // value
  logic               m_axis_tuser;  // span_error

  // predictor state and configuration copy
  logic [DataW-1:0]  seed_q;
  logic [DataW-1:0]  taps_long_q;
  logic [ShortW-1:0] taps_short_q;
  logic [DataW-1:0]  lfsr_long_q;
  logic [ShortW-1:0] lfsr_short_q;

  request_t   requests_q[$];
  rand_word_t words_due[$];
  request_t   offered;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_kick = 1'b0;
  int unsigned hold_left;
  int unsigned mismatches = 0;

  combined_lfsr_random_range uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [DataW-1:0] shift_galois(input logic [DataW-1:0] r,
                                                    input logic [DataW-1:0] mask);
    logic [DataW-1:0] n;
    n = r >> 1;
    if (r[0]) begin
      n = n ^ mask;
    end
    return n;
  endfunction

  function automatic void load_lfsrs();
    logic [DataW-1:0] sum;
    sum          = seed_q + SeedOffset;
    lfsr_long_q  = seed_q % ModLong;
    lfsr_short_q = ShortW'(sum % ModShort);
  endfunction

  // computes the word the block returns for one request and queues it
  function automatic void next_random_word(input request_t req);
    rand_word_t       w;
    logic [DataW-1:0] span;
    logic [DataW-1:0] nxt;
    logic [RawW-1:0]  raw;
    span = req.hi - req.lo;
    if (req.func == FuncRange && span == '0) begin
      // equal bounds: error word, lfsrs hold
      w.value      = '0;
      w.span_error = 1'b1;
    end else begin
      lfsr_long_q  = shift_galois(shift_galois(lfsr_long_q, taps_long_q), taps_long_q);
      nxt          = shift_galois({1'b0, lfsr_short_q}, {1'b0, taps_short_q});
      lfsr_short_q = nxt[ShortW-1:0];
      raw          = lfsr_long_q[RawW-1:0] ^ lfsr_short_q[RawW-1:0];
      w.span_error = 1'b0;
      if (req.func == FuncRange) begin
        w.value = ({{(DataW-RawW){1'b0}}, raw} % span) + req.lo;
      end else begin
        w.value = {{(DataW-RawW){1'b0}}, raw};
      end
    end
    words_due.push_back(w);
  endfunction

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      REG_SEED: begin
        seed_q = data;
        load_lfsrs();
      end
      REG_TAPS_LONG:  taps_long_q = data;
      REG_TAPS_SHORT: taps_short_q = data[ShortW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_request(input logic func, input logic [DataW-1:0] lo,
                              input logic [DataW-1:0] hi);
    request_t r;
    r.func = func;
    r.lo   = lo;
    r.hi   = hi;
    requests_q.push_back(r);
  endtask

  function automatic request_t rand_request();
    request_t r;
    r.func = ($urandom_range(3) != 0) ? FuncRange : FuncRaw;
    r.lo   = $urandom();
    case ($urandom_range(9))
      0, 1, 2: r.hi = r.lo + $urandom_range(1, 300);
      3, 4:    r.hi = r.lo + $urandom_range(301, 140000);
      5, 6:    r.hi = $urandom();
      7:       r.hi = r.lo;
      8:       r.hi = r.lo - $urandom_range(1, 1000);
      default: begin
        // small bounds around zero
        r.lo = $urandom_range(200) - 32'd100;
        r.hi = r.lo + $urandom_range(1, 50);
      end
    endcase
    return r;
  endfunction

  // sampled between edges so queue and handshake state are settled
  task automatic wait_all_words();
    do begin
      @(negedge clk_i);
    end while (requests_q.size() != 0 || s_axis_tvalid || words_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned n, input int unsigned sidle,
                            input int unsigned rstall);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    for (int unsigned i = 0; i < n; i++) begin
      requests_q.push_back(rand_request());
    end
    wait_all_words();
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    logic busy;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        next_random_word(offered);
        busy = 1'b0;
      end
      if (!busy) begin
        if (requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = requests_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {offered.hi, offered.lo};
          s_axis_tuser  <= offered.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : check_words
    rand_word_t w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (words_due.size() == 0) begin
          $display("%0t: unexpected word value %h span_error %b",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          w = words_due.pop_front();
          if (m_axis_tdata !== w.value) begin
            $display("%0t: value expected %h actual %h", $time, w.value, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tuser !== w.span_error) begin
            $display("%0t: span_error expected %b actual %b",
                     $time, w.span_error, m_axis_tuser);
            mismatches++;
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    seed_q       = ResetSeed;
    taps_long_q  = ResetTapsLong;
    taps_short_q = ResetTapsShort;
    load_lfsrs();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part on reset configuration
    push_request(FuncRaw,   32'h0000_0000, 32'h0000_0000);
    push_request(FuncRaw,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(FuncRaw,   32'h8000_0000, 32'h7FFF_FFFF);
    push_request(FuncRange, 32'h0000_0000, 32'h0000_0000);
    push_request(FuncRange, 32'h8000_0000, 32'h8000_0000);
    push_request(FuncRange, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(FuncRaw,   32'h1234_5678, 32'h1234_5678);
    push_request(FuncRange, 32'h0000_0000, 32'h0000_0001);
    push_request(FuncRange, 32'h7FFF_FFFF, 32'h8000_0000);
    push_request(FuncRange, 32'hFFFF_FFFF, 32'h0000_0000);
    push_request(FuncRange, 32'h8000_0000, 32'h7FFF_FFFF);
    push_request(FuncRange, 32'h0000_0000, 32'hFFFF_FFFF);
    push_request(FuncRange, 32'h0000_0001, 32'h0000_0000);
    push_request(FuncRange, 32'h0000_0064, 32'hFFFF_FFFB);
    push_request(FuncRange, 32'h7FFF_FFF0, 32'h8000_0010);
    push_request(FuncRange, 32'hFFFF_FFF6, 32'h0000_000A);
    push_request(FuncRange, 32'h0000_0000, 32'h0000_FFFF);
    push_request(FuncRange, 32'hFFFF_0000, 32'h0000_0000);
    push_request(FuncRange, 32'hFFFF_FF9C, 32'h0000_FF9D);
    push_request(FuncRange, 32'h8000_0000, 32'h8000_0002);
    run_random(90, 0, 0);

    write_reg(REG_SEED, $urandom());
    write_reg(REG_TAPS_LONG, $urandom());
    write_reg(REG_TAPS_SHORT, $urandom());
    run_random(110, 88, 0);

    // extremes: all-ones seed wraps the long lfsr to zero, oversized short taps
    write_reg(REG_SEED, 32'hFFFF_FFFF);
    write_reg(REG_TAPS_LONG, 32'hFFFF_FFFF);
    write_reg(REG_TAPS_SHORT, 32'hFFFF_FFFF);
    write_reg(RegUnused, $urandom());
    run_random(110, 0, 88);

    write_reg(REG_TAPS_LONG, 32'h0000_0000);
    write_reg(REG_TAPS_SHORT, 32'h0000_0000);
    write_reg(REG_SEED, 32'h0000_0000);
    @(posedge clk_i);
    hold_kick <= 1'b1;
    @(posedge clk_i);
    hold_kick <= 1'b0;
    run_random(110, 37, 37);

    write_reg(REG_TAPS_SHORT, 32'h7FFF_FFFF);
    write_reg(REG_TAPS_LONG, ResetTapsLong);
    write_reg(REG_SEED, $urandom());
    run_random(110, 0, 0);

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
